>>> hw/rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg: shared types and constants for the text console char writer
// Character codes, result action codes and the control/status bundles that
// pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // control characters
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // tab stops every eight columns
  localparam logic [3:0] TAB_STOP = 4'd8;

  // result action codes
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_SCROLL = 2'd1;
  localparam logic [1:0] ACT_MOVE   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_FG   = 2'd2;
  localparam logic [1:0] REG_BG   = 2'd3;

  // sequencer to datapath
  typedef struct packed {
    logic load;         // take a new character, clamp the cursor
    logic emit_step;    // produce the main result for the character
    logic emit_scroll;  // produce the scroll result after a wrapping write
  } cmd_t;

  // datapath to sequencer
  typedef struct packed {
    logic single;       // line feed, carriage return or backspace
    logic wrap_scroll;  // a cell write here wraps past the bottom row
    logic step_last;    // no more spaces after this write (no scroll case)
    logic scroll_last;  // no more spaces after the pending scroll
    logic out_free;     // output register can take a result this cycle
  } status_t;

endpackage

>>> hw/rtl/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// tccw_ctrl: sequencer for the text console char writer
// Takes one character while idle, then steps through its results one per
// cycle, waiting whenever the output register is still occupied.
// ----------------------------------------------------------------------------
module tccw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  tccw_pkg::status_t status,
  output tccw_pkg::cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_STEP   = 2'd1;
  localparam logic [1:0] ST_SCROLL = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == ST_IDLE);

  // command decode and next state
  always_comb begin
    state_next      = state;
    cmd.load        = 1'b0;
    cmd.emit_step   = 1'b0;
    cmd.emit_scroll = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (status.out_free) begin
          cmd.emit_step = 1'b1;
          if (status.single) begin
            state_next = ST_IDLE;
          end else if (status.wrap_scroll) begin
            state_next = ST_SCROLL;
          end else if (status.step_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SCROLL: begin
        if (status.out_free) begin
          cmd.emit_scroll = 1'b1;
          state_next      = status.scroll_last ? ST_IDLE : ST_STEP;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/tccw_dp.sv
// ----------------------------------------------------------------------------
// tccw_dp: datapath for the text console char writer
// Holds the screen settings, the cursor, the current character, the tab
// space count and the output result register.
// ----------------------------------------------------------------------------
module tccw_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic [7:0]        char_code,
  input  tccw_pkg::cmd_t    cmd,
  output tccw_pkg::status_t status,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [55:0]       m_tdata,
  output logic              m_tlast
);

  logic [7:0] screen_rows;
  logic [7:0] screen_cols;
  logic [3:0] fg_color;
  logic [3:0] bg_color;
  logic [7:0] cur_row;
  logic [7:0] cur_col;
  logic [7:0] char_reg;
  logic [3:0] tab_cnt;

  logic       out_valid;
  logic [1:0] out_action;
  logic [7:0] out_cell_row;
  logic [7:0] out_cell_col;
  logic [7:0] out_cell_char;
  logic [7:0] out_cell_attr;
  logic [7:0] out_cursor_row;
  logic [7:0] out_cursor_col;
  logic       out_last;

  logic [7:0] rows_m1;
  logic [7:0] cols_m1;
  logic [7:0] row_clamp;
  logic [7:0] col_clamp;
  logic [7:0] attr;
  logic       is_lf;
  logic       is_cr;
  logic       is_bs;
  logic       is_tab;
  logic       at_end_col;
  logic       at_bottom;
  logic       emit;

  // last row and column index, a zero size counts as one
  assign rows_m1 = (screen_rows == 8'd0) ? 8'd0 : screen_rows - 8'd1;
  assign cols_m1 = (screen_cols == 8'd0) ? 8'd0 : screen_cols - 8'd1;

  // cursor pulled back onto a screen that shrank
  assign row_clamp = (cur_row > rows_m1) ? rows_m1 : cur_row;
  assign col_clamp = (cur_col > cols_m1) ? cols_m1 : cur_col;

  assign attr = {bg_color, fg_color};

  // character decode
  assign is_lf  = (char_reg == tccw_pkg::CH_LF);
  assign is_cr  = (char_reg == tccw_pkg::CH_CR);
  assign is_bs  = (char_reg == tccw_pkg::CH_BS);
  assign is_tab = (char_reg == tccw_pkg::CH_TAB);

  assign at_end_col = (cur_col == cols_m1);
  assign at_bottom  = (cur_row == rows_m1);

  // status back to the sequencer
  assign status.single      = is_lf | is_cr | is_bs;
  assign status.wrap_scroll = at_end_col & at_bottom;
  assign status.step_last   = ~is_tab | (tab_cnt == 4'd1);
  assign status.scroll_last = ~is_tab | (tab_cnt == 4'd0);
  assign status.out_free    = ~out_valid | m_tready;

  assign emit = cmd.emit_step | cmd.emit_scroll;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_rows <= 8'd25;
      screen_cols <= 8'd80;
      fg_color    <= 4'd7;
      bg_color    <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        tccw_pkg::REG_ROWS: screen_rows <= cfg_data;
        tccw_pkg::REG_COLS: screen_cols <= cfg_data;
        tccw_pkg::REG_FG:   fg_color    <= cfg_data[3:0];
        tccw_pkg::REG_BG:   bg_color    <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // cursor: clamp on load, move on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= 8'd0;
      cur_col <= 8'd0;
    end else if (cmd.load) begin
      cur_row <= row_clamp;
      cur_col <= col_clamp;
    end else if (cmd.emit_step) begin
      if (is_lf) begin
        cur_col <= 8'd0;
        if (!at_bottom) begin
          cur_row <= cur_row + 8'd1;
        end
      end else if (is_cr) begin
        cur_col <= 8'd0;
      end else if (is_bs) begin
        if (cur_col != 8'd0) begin
          cur_col <= cur_col - 8'd1;
        end
      end else if (at_end_col) begin
        cur_col <= 8'd0;
        if (!at_bottom) begin
          cur_row <= cur_row + 8'd1;
        end
      end else begin
        cur_col <= cur_col + 8'd1;
      end
    end
  end

  // current character and remaining tab spaces
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_reg <= char_code;
      tab_cnt  <= tccw_pkg::TAB_STOP - {1'b0, col_clamp[2:0]};
    end else if (cmd.emit_step && is_tab) begin
      tab_cnt <= tab_cnt - 4'd1;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // output result payload
  always_ff @(posedge clk) begin
    if (cmd.emit_scroll) begin
      out_action     <= tccw_pkg::ACT_SCROLL;
      out_cell_row   <= 8'd0;
      out_cell_col   <= 8'd0;
      out_cell_char  <= 8'd0;
      out_cell_attr  <= attr;
      out_cursor_row <= cur_row;
      out_cursor_col <= cur_col;
      out_last       <= status.scroll_last;
    end else if (cmd.emit_step) begin
      out_cell_row   <= 8'd0;
      out_cell_col   <= 8'd0;
      out_cell_char  <= 8'd0;
      out_cell_attr  <= 8'd0;
      out_cursor_row <= cur_row;
      out_cursor_col <= 8'd0;
      out_last       <= 1'b1;
      out_action     <= tccw_pkg::ACT_MOVE;
      if (is_lf) begin
        if (at_bottom) begin
          out_action    <= tccw_pkg::ACT_SCROLL;
          out_cell_attr <= attr;
        end else begin
          out_cursor_row <= cur_row + 8'd1;
        end
      end else if (is_cr) begin
        out_cursor_col <= 8'd0;
      end else if (is_bs) begin
        out_cursor_col <= (cur_col == 8'd0) ? 8'd0 : cur_col - 8'd1;
      end else begin
        // cell write, cursor after advance and wrap
        out_action    <= tccw_pkg::ACT_WRITE;
        out_cell_row  <= cur_row;
        out_cell_col  <= cur_col;
        out_cell_char <= is_tab ? tccw_pkg::CH_SPACE : char_reg;
        out_cell_attr <= attr;
        out_last      <= status.step_last & ~status.wrap_scroll;
        if (at_end_col) begin
          out_cursor_col <= 8'd0;
          if (!at_bottom) begin
            out_cursor_row <= cur_row + 8'd1;
          end
        end else begin
          out_cursor_col <= cur_col + 8'd1;
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {6'd0, out_cursor_col, out_cursor_row, out_cell_attr,
                     out_cell_char, out_cell_col, out_cell_row, out_action};

endmodule

>>> hw/rtl/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer: text screen cursor and cell writer
// Turns a stream of character codes into cell writes, scroll commands and
// cursor moves for a text-mode screen.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one character per item (s_tdata[7:0]). m_* gives result items;
//   m_tlast marks the final result of a character. A printed character gives
//   a write, plus a scroll when it wraps past the bottom row; a tab gives this
//   for each space up to the next multiple of eight columns (up to 16
//   results); line feed, carriage return and backspace give one result each.
//   The cfg_* port writes screen size and colors; write it only while idle.
// Timing:
//   a character is first loaded and the cursor clamped, then its results
//   follow one per cycle while the output is not stalled. The sequencer
//   handles one character at a time; s_tready is high only while it is idle.
// Reset and stall:
//   reset puts the cursor at row 0, column 0 and the settings to 25 rows,
//   80 columns, light grey on black. A held result stays in the output
//   register and the sequencer waits until the receiver takes it.
// ----------------------------------------------------------------------------
module text_console_char_writer (
  input  logic        clk,
  input  logic        rst,
  // config: 0 rows, 1 columns, 2 foreground, 3 background
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] action, [9:2] cell_row, [17:10] cell_col, [25:18] cell_char,
  // [33:26] cell_attr, [41:34] cursor_row, [49:42] cursor_col, rest zero
  output logic [55:0] m_tdata,
  output logic        m_tlast    // last result of a character
);

  tccw_pkg::cmd_t    cmd;
  tccw_pkg::status_t status;

  // sequencer
  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  tccw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .char_code (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

>>> hw/rtl/tccw_check.sv
// ----------------------------------------------------------------------------
// tccw_check: port checks for the text console char writer
// Watches the stream ports and flags input handshakes and results the writer can never produce.
// ----------------------------------------------------------------------------
module tccw_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tlast
);

  // one character at a time: busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an item was taken");

  // action code is one of write, scroll, move
  a_action_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == tccw_pkg::ACT_WRITE ||
                  m_tdata[1:0] == tccw_pkg::ACT_SCROLL ||
                  m_tdata[1:0] == tccw_pkg::ACT_MOVE))
    else $error("unknown action code");

  // a cursor move always closes its character
  a_move_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == tccw_pkg::ACT_MOVE |-> m_tlast)
    else $error("cursor move result not marked last");

  // no new character accepted while results of the last one are pending
  a_no_accept_mid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready while a character still has results");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind text_console_char_writer tccw_check u_check (.*);
